>>> sv/bef_pkg.sv
// ----------------------------------------------------------------------------
// bef_pkg
// shared widths, codes, types and helpers for the bandwidth estimate fusion
// ----------------------------------------------------------------------------
package bef_pkg;

    localparam int RATE_WIDTH = 32;
    localparam int TIME_WIDTH = 48;
    localparam int CONF_WIDTH = 16;
    localparam int CFG_WIDTH  = 32;
    localparam int VAL_WIDTH  = (RATE_WIDTH > CFG_WIDTH) ? RATE_WIDTH : CFG_WIDTH;

    localparam int SRC_COUNT = 3;
    localparam int MODE_WIDTH = 2;
    localparam int CFG_INDEX_WIDTH = 3;

    localparam logic [MODE_WIDTH-1:0] MODE_ECN   = 2'd0;
    localparam logic [MODE_WIDTH-1:0] MODE_PROBE = 2'd1;
    localparam logic [MODE_WIDTH-1:0] MODE_ACKED = 2'd2;
    localparam logic [MODE_WIDTH-1:0] MODE_QUERY = 2'd3;

    localparam int SRC_ECN   = 0;
    localparam int SRC_PROBE = 1;
    localparam int SRC_ACKED = 2;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PROBE_CONF_THR = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ECN_CONF_THR   = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ACKED_CONF_THR = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RECENT_WINDOW  = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RATE_FLOOR     = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEFAULT_RATE   = 3'd5;

    localparam logic [CONF_WIDTH-1:0] RST_PROBE_CONF_THR = 16'd32768;
    localparam logic [CONF_WIDTH-1:0] RST_ECN_CONF_THR   = 16'd32768;
    localparam logic [CONF_WIDTH-1:0] RST_ACKED_CONF_THR = 16'd19661;
    localparam logic [CFG_WIDTH-1:0]  RST_RECENT_WINDOW  = 32'd10000000;
    localparam logic [CFG_WIDTH-1:0]  RST_RATE_FLOOR     = 32'd20000;
    localparam logic [CFG_WIDTH-1:0]  RST_DEFAULT_RATE   = 32'd300000;

    typedef struct packed {
        logic [CONF_WIDTH-1:0] probe_conf_thr;
        logic [CONF_WIDTH-1:0] ecn_conf_thr;
        logic [CONF_WIDTH-1:0] acked_conf_thr;
        logic [CFG_WIDTH-1:0]  recent_window;
        logic [CFG_WIDTH-1:0]  rate_floor;
        logic [CFG_WIDTH-1:0]  default_rate;
    } cfg_t;

    typedef struct packed {
        logic [VAL_WIDTH-1:0]  rate;
        logic [CONF_WIDTH-1:0] conf;
        logic [TIME_WIDTH-1:0] stamp;
        logic                  seen;
    } src_t;

    typedef src_t [SRC_COUNT-1:0] src_bank_t;

    function automatic logic [VAL_WIDTH-1:0] raise_to(
        input logic [VAL_WIDTH-1:0] a,
        input logic [VAL_WIDTH-1:0] b
    );
        return (a < b) ? b : a;
    endfunction

endpackage

>>> sv/bef_cfg_regs.sv
// ----------------------------------------------------------------------------
// bef_cfg_regs
// configuration register file written through the cfg transaction port
// ----------------------------------------------------------------------------
module bef_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bef_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [bef_pkg::CFG_WIDTH-1:0]       cfg_data,
    output bef_pkg::cfg_t                       cfg
);
    import bef_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PROBE_CONF_THR: cfg_next.probe_conf_thr = cfg_data[CONF_WIDTH-1:0];
                REG_ECN_CONF_THR:   cfg_next.ecn_conf_thr   = cfg_data[CONF_WIDTH-1:0];
                REG_ACKED_CONF_THR: cfg_next.acked_conf_thr = cfg_data[CONF_WIDTH-1:0];
                REG_RECENT_WINDOW:  cfg_next.recent_window  = cfg_data;
                REG_RATE_FLOOR:     cfg_next.rate_floor     = cfg_data;
                REG_DEFAULT_RATE:   cfg_next.default_rate   = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.probe_conf_thr <= RST_PROBE_CONF_THR;
            cfg_reg.ecn_conf_thr   <= RST_ECN_CONF_THR;
            cfg_reg.acked_conf_thr <= RST_ACKED_CONF_THR;
            cfg_reg.recent_window  <= RST_RECENT_WINDOW;
            cfg_reg.rate_floor     <= RST_RATE_FLOOR;
            cfg_reg.default_rate   <= RST_DEFAULT_RATE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> sv/bef_source_bank.sv
// ----------------------------------------------------------------------------
// bef_source_bank
// ecn, probe and acked estimate registers with write-through view
// ----------------------------------------------------------------------------
module bef_source_bank (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [bef_pkg::MODE_WIDTH-1:0]  mode,
    input  logic [bef_pkg::RATE_WIDTH-1:0]  rate,
    input  logic [bef_pkg::CONF_WIDTH-1:0]  conf,
    input  logic [bef_pkg::TIME_WIDTH-1:0]  stamp,
    input  bef_pkg::cfg_t                   cfg,
    output bef_pkg::src_bank_t              view
);
    import bef_pkg::*;

    src_bank_t bank_reg;
    src_bank_t bank_next;
    logic [VAL_WIDTH-1:0] wr_rate;

    always_comb
    begin
        wr_rate = VAL_WIDTH'(rate);
        if (mode == MODE_ECN)
        begin
            wr_rate = raise_to(VAL_WIDTH'(rate), VAL_WIDTH'(cfg.rate_floor));
        end
        bank_next = bank_reg;
        for (int s = 0; s < SRC_COUNT; s++)
        begin
            if ((mode != MODE_QUERY) && (mode == MODE_WIDTH'(s)))
            begin
                bank_next[s].rate  = wr_rate;
                bank_next[s].conf  = conf;
                bank_next[s].stamp = stamp;
                bank_next[s].seen  = 1'b1;
            end
        end
    end

    // fusion sees the state after this item's write
    assign view = bank_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg <= '0;
        end
        else if (wr_en)
        begin
            bank_reg <= bank_next;
        end
    end

endmodule

>>> sv/bef_fusion.sv
// ----------------------------------------------------------------------------
// bef_fusion
// recency checks, discovery-mode source selection and the guarded ecn rate
// ----------------------------------------------------------------------------
module bef_fusion (
    input  bef_pkg::src_bank_t              bank,
    input  bef_pkg::cfg_t                   cfg,
    input  logic [bef_pkg::TIME_WIDTH-1:0]  now,
    output logic [bef_pkg::VAL_WIDTH-1:0]   discovery_rate,
    output logic [bef_pkg::VAL_WIDTH-1:0]   guarded_ecn_rate
);
    import bef_pkg::*;

    logic [TIME_WIDTH-1:0] age [SRC_COUNT];
    logic [SRC_COUNT-1:0]  recent;
    logic                  ecn_ok;
    logic                  probe_ok;
    logic                  acked_ok;
    logic [VAL_WIDTH-1:0]  best_rate;
    logic [CONF_WIDTH-1:0] best_conf;
    logic [VAL_WIDTH-1:0]  picked;
    logic [VAL_WIDTH-1:0]  floored;

    always_comb
    begin
        for (int s = 0; s < SRC_COUNT; s++)
        begin
            age[s]    = now - bank[s].stamp;
            recent[s] = bank[s].seen &&
                        (age[s][TIME_WIDTH-1] || (age[s] < TIME_WIDTH'(cfg.recent_window)));
        end
    end

    assign ecn_ok   = (bank[SRC_ECN].conf > cfg.ecn_conf_thr) && recent[SRC_ECN];
    assign probe_ok = (bank[SRC_PROBE].conf > cfg.probe_conf_thr) && recent[SRC_PROBE];
    assign acked_ok = (bank[SRC_ACKED].conf > cfg.acked_conf_thr) && recent[SRC_ACKED];

    // most confident recent source, ties keep the earlier one
    always_comb
    begin
        best_rate = VAL_WIDTH'(cfg.default_rate);
        best_conf = '0;
        for (int s = 0; s < SRC_COUNT; s++)
        begin
            if ((bank[s].conf > best_conf) && recent[s])
            begin
                best_rate = bank[s].rate;
                best_conf = bank[s].conf;
            end
        end
    end

    always_comb
    begin
        priority if (ecn_ok)
        begin
            picked = bank[SRC_ECN].rate;
        end
        else if (probe_ok)
        begin
            picked = bank[SRC_PROBE].rate;
        end
        else
        begin
            picked = best_rate;
        end
        floored = acked_ok ? raise_to(picked, bank[SRC_ACKED].rate) : picked;
    end

    assign discovery_rate   = raise_to(floored, VAL_WIDTH'(cfg.rate_floor));
    assign guarded_ecn_rate = raise_to(bank[SRC_ECN].rate, VAL_WIDTH'(cfg.rate_floor));

endmodule

>>> sv/bandwidth_estimate_fusion_core.sv
// ----------------------------------------------------------------------------
// bandwidth_estimate_fusion_core
// fuses ecn, probe and acked rate estimates into a discovery rate
// path: input transaction held in the input reg, then fused into the result reg
// throughput: 1 transaction per cycle while the output is not stalled, fusion logic is combinational
// reset: estimates cleared and marked unseen, config back to defaults
// ----------------------------------------------------------------------------
module bandwidth_estimate_fusion_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [bef_pkg::MODE_WIDTH-1:0]      mode,
    input  logic [bef_pkg::RATE_WIDTH-1:0]      rate_bps,
    input  logic [bef_pkg::CONF_WIDTH-1:0]      confidence,
    input  logic [bef_pkg::TIME_WIDTH-1:0]      time_us,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [bef_pkg::RATE_WIDTH-1:0]      discovery_rate_bps,
    output logic [bef_pkg::RATE_WIDTH-1:0]      guarded_ecn_rate_bps,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bef_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [bef_pkg::CFG_WIDTH-1:0]       cfg_data
);
    import bef_pkg::*;

    cfg_t      cfg;
    src_bank_t view;

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic [MODE_WIDTH-1:0] s1_mode_reg;
    logic [RATE_WIDTH-1:0] s1_rate_reg;
    logic [CONF_WIDTH-1:0] s1_conf_reg;
    logic [TIME_WIDTH-1:0] s1_time_reg;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [RATE_WIDTH-1:0] discovery_reg;
    logic [RATE_WIDTH-1:0] guarded_reg;

    logic [VAL_WIDTH-1:0]  discovery_val;
    logic [VAL_WIDTH-1:0]  guarded_val;

    logic out_ready;
    logic advance;
    logic in_accept;

    bef_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bef_source_bank u_bank (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (advance),
        .mode  (s1_mode_reg),
        .rate  (s1_rate_reg),
        .conf  (s1_conf_reg),
        .stamp (s1_time_reg),
        .cfg   (cfg),
        .view  (view)
    );

    bef_fusion u_fusion (
        .bank             (view),
        .cfg              (cfg),
        .now              (s1_time_reg),
        .discovery_rate   (discovery_val),
        .guarded_ecn_rate (guarded_val)
    );

    assign out_ready = !out_valid_reg || !out_stall;
    assign advance   = s1_valid_reg && out_ready;
    assign in_stall  = s1_valid_reg && !out_ready;
    assign in_accept = in_valid && !in_stall;

    assign s1_valid_next  = in_accept || (s1_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    assign out_valid            = out_valid_reg;
    assign discovery_rate_bps   = discovery_reg;
    assign guarded_ecn_rate_bps = guarded_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_mode_reg <= mode;
            s1_rate_reg <= rate_bps;
            s1_conf_reg <= confidence;
            s1_time_reg <= time_us;
        end
        if (advance)
        begin
            discovery_reg <= discovery_val[RATE_WIDTH-1:0];
            guarded_reg   <= guarded_val[RATE_WIDTH-1:0];
        end
    end

    a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with empty input register");

    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("transaction advanced but no result presented");

    a_held_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> (s1_valid_reg && $stable(s1_time_reg)))
        else $error("held input transaction lost or changed");

    a_no_advance_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !advance)
        else $error("result overwritten while stalled");

endmodule

>>> test/bandwidth_estimate_fusion_core_tb.sv
// ----------------------------------------------------------------------------
// bandwidth_estimate_fusion_core_tb
// self-checking bench for the ecn / probe / acked rate fusion core. a
// directed sequence covers confidence thresholds, the recent window edge,
// negative and wrapped ages, tie breaking and the default and floor paths.
// random phases then rewrite every register, including the extremes, and run
// timed estimate updates and queries. the sender idles in bursts and the
// receiver stalls on changing patterns. a scoreboard class predicts both
// output rates for each input transaction and checks them in order.
// ----------------------------------------------------------------------------
module bandwidth_estimate_fusion_core_tb;
    import bef_pkg::*;

    typedef struct packed {
        logic [RATE_WIDTH-1:0] discovery;
        logic [RATE_WIDTH-1:0] guarded_ecn;
    } rate_pair_t;

    class rate_fusion_tracker;
        logic [RATE_WIDTH-1:0] src_rate [SRC_COUNT];
        logic [CONF_WIDTH-1:0] src_conf [SRC_COUNT];
        logic [TIME_WIDTH-1:0] src_stamp [SRC_COUNT];
        bit                    src_seen [SRC_COUNT];
        logic [CONF_WIDTH-1:0] probe_thr;
        logic [CONF_WIDTH-1:0] ecn_thr;
        logic [CONF_WIDTH-1:0] acked_thr;
        logic [CFG_WIDTH-1:0]  window_us;
        logic [CFG_WIDTH-1:0]  floor_bps;
        logic [CFG_WIDTH-1:0]  default_bps;
        rate_pair_t            expected_rates [$];
        int                    failures;
        int                    checked;

        function new();
            probe_thr   = RST_PROBE_CONF_THR;
            ecn_thr     = RST_ECN_CONF_THR;
            acked_thr   = RST_ACKED_CONF_THR;
            window_us   = RST_RECENT_WINDOW;
            floor_bps   = RST_RATE_FLOOR;
            default_bps = RST_DEFAULT_RATE;
            for (int s = 0; s < SRC_COUNT; s++)
            begin
                src_rate[s]  = '0;
                src_conf[s]  = '0;
                src_stamp[s] = '0;
                src_seen[s]  = 1'b0;
            end
            failures = 0;
            checked  = 0;
        endfunction

        function void write_register(logic [CFG_INDEX_WIDTH-1:0] index,
                                     logic [CFG_WIDTH-1:0] data);
            case (index)
                REG_PROBE_CONF_THR: probe_thr   = data[CONF_WIDTH-1:0];
                REG_ECN_CONF_THR:   ecn_thr     = data[CONF_WIDTH-1:0];
                REG_ACKED_CONF_THR: acked_thr   = data[CONF_WIDTH-1:0];
                REG_RECENT_WINDOW:  window_us   = data;
                REG_RATE_FLOOR:     floor_bps   = data;
                REG_DEFAULT_RATE:   default_bps = data;
                default: ;
            endcase
        endfunction

        // age is taken modulo the time width, a negative age counts as recent
        function bit is_recent(int s, logic [TIME_WIDTH-1:0] now);
            logic [TIME_WIDTH-1:0] age;
            age = now - src_stamp[s];
            if (!src_seen[s])
                return 1'b0;
            if (age[TIME_WIDTH-1])
                return 1'b1;
            return age < window_us;
        endfunction

        function logic [RATE_WIDTH-1:0] expected_discovery(logic [TIME_WIDTH-1:0] now);
            logic [RATE_WIDTH-1:0] r;
            logic [CONF_WIDTH-1:0] best_conf;
            if (src_conf[SRC_ECN] > ecn_thr && is_recent(SRC_ECN, now))
                r = src_rate[SRC_ECN];
            else if (src_conf[SRC_PROBE] > probe_thr && is_recent(SRC_PROBE, now))
                r = src_rate[SRC_PROBE];
            else
            begin
                // strictly higher confidence wins, ties keep the earlier source
                r = default_bps[RATE_WIDTH-1:0];
                best_conf = '0;
                for (int s = 0; s < SRC_COUNT; s++)
                begin
                    if (src_conf[s] > best_conf && is_recent(s, now))
                    begin
                        r = src_rate[s];
                        best_conf = src_conf[s];
                    end
                end
            end
            if (src_conf[SRC_ACKED] > acked_thr && is_recent(SRC_ACKED, now)
                && r < src_rate[SRC_ACKED])
                r = src_rate[SRC_ACKED];
            if (r < floor_bps)
                r = floor_bps[RATE_WIDTH-1:0];
            return r;
        endfunction

        function void note_estimate(logic [MODE_WIDTH-1:0] op, logic [RATE_WIDTH-1:0] rate,
                                    logic [CONF_WIDTH-1:0] conf, logic [TIME_WIDTH-1:0] now);
            rate_pair_t want;
            if (op != MODE_QUERY)
            begin
                if (op == MODE_ECN && rate < floor_bps)
                    rate = floor_bps[RATE_WIDTH-1:0];
                src_rate[op]  = rate;
                src_conf[op]  = conf;
                src_stamp[op] = now;
                src_seen[op]  = 1'b1;
            end
            want.discovery   = expected_discovery(now);
            want.guarded_ecn = (src_rate[SRC_ECN] < floor_bps) ? floor_bps[RATE_WIDTH-1:0]
                                                                : src_rate[SRC_ECN];
            expected_rates.push_back(want);
        endfunction

        function void check_rates(logic [RATE_WIDTH-1:0] discovery,
                                  logic [RATE_WIDTH-1:0] guarded);
            rate_pair_t want;
            if (expected_rates.size() == 0)
            begin
                $display("%0t: result with nothing pending, discovery %0d guarded_ecn %0d",
                         $time, discovery, guarded);
                failures++;
                return;
            end
            want = expected_rates.pop_front();
            checked++;
            if (discovery !== want.discovery)
            begin
                $display("%0t: discovery_rate_bps expected %0d actual %0d",
                         $time, want.discovery, discovery);
                failures++;
            end
            if (guarded !== want.guarded_ecn)
            begin
                $display("%0t: guarded_ecn_rate_bps expected %0d actual %0d",
                         $time, want.guarded_ecn, guarded);
                failures++;
            end
        endfunction

        function int pending();
            return expected_rates.size();
        endfunction
    endclass

    localparam int IDLE_LIMIT = 5000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS = 192;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_HI = 3'd7;

    typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PATTERN} stall_style_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [MODE_WIDTH-1:0]      mode = MODE_QUERY;
    logic [RATE_WIDTH-1:0]      rate_bps = '0;
    logic [CONF_WIDTH-1:0]      confidence = '0;
    logic [TIME_WIDTH-1:0]      time_us = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [RATE_WIDTH-1:0]      discovery_rate_bps;
    logic [RATE_WIDTH-1:0]      guarded_ecn_rate_bps;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_WIDTH-1:0]       cfg_data = '0;

    rate_fusion_tracker tracker;
    int                 idle_cycles = 0;
    int                 burst_left = 0;
    int                 items_sent = 0;
    int                 directed_items = 0;
    int                 cfg_writes = 0;
    logic [TIME_WIDTH-1:0] now_t = '0;
    stall_style_t       stall_style = STALL_NONE;
    int                 stall_left = 0;
    logic [7:0]         stall_mask = '0;
    logic [2:0]         stall_tick = '0;

    bandwidth_estimate_fusion_core i_dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (in_valid),
        .in_stall             (in_stall),
        .mode                 (mode),
        .rate_bps             (rate_bps),
        .confidence           (confidence),
        .time_us              (time_us),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .discovery_rate_bps   (discovery_rate_bps),
        .guarded_ecn_rate_bps (guarded_ecn_rate_bps),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver stall, style and pattern chosen at random and changed from time to time
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_style = stall_style_t'($urandom_range(0, 3));
            stall_mask = 8'($urandom_range(0, 255));
            stall_mask[0] = 1'b0;
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        stall_tick++;
        case (stall_style)
            STALL_NONE:  out_stall = 1'b0;
            STALL_LIGHT: out_stall = ($urandom_range(0, 7) == 0);
            STALL_HEAVY: out_stall = ($urandom_range(0, 3) != 0);
            default:     out_stall = stall_mask[stall_tick];
        endcase
    end

    // result check and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                tracker.check_rates(discovery_rate_bps, guarded_ecn_rate_bps);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles, %0d results pending",
                         $time, IDLE_LIMIT, tracker.pending());
                $display("FAIL bandwidth_estimate_fusion_core");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_estimate(input logic [MODE_WIDTH-1:0] op, input logic [RATE_WIDTH-1:0] rate,
                                 input logic [CONF_WIDTH-1:0] conf, input logic [TIME_WIDTH-1:0] stamp);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_valid   = 1'b1;
        mode       = op;
        rate_bps   = rate;
        confidence = conf;
        time_us    = stamp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.note_estimate(op, rate, conf, stamp);
        items_sent++;
        burst_left--;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] index, input logic [CFG_WIDTH-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tracker.write_register(index, data);
        cfg_writes++;
        @(negedge clk);
    endtask

    function automatic logic [CONF_WIDTH-1:0] pick_threshold(input int phase);
        if (phase == 0)
            return '0;
        if (phase == 1)
            return '1;
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            2:       return RST_PROBE_CONF_THR;
            default: return CONF_WIDTH'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [CFG_WIDTH-1:0] pick_window(input int phase);
        logic [CFG_WIDTH-1:0] w;
        if (phase == 0)
            return 1;
        if (phase == 1)
            return '1;
        case ($urandom_range(0, 4))
            0:       w = $urandom_range(1, 64);
            1:       w = $urandom_range(1000, 100000);
            2:       w = $urandom_range(1000000, 20000000);
            3:       w = '1;
            default: w = $urandom;
        endcase
        return (w == 0) ? 1 : w;
    endfunction

    function automatic logic [CFG_WIDTH-1:0] pick_floor(input int phase);
        if (phase == 0 || phase == 1)
            return '0;
        if (phase == 2)
            return '1;
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return $urandom_range(0, 100000);
            2:       return $urandom;
            default: return RST_RATE_FLOOR;
        endcase
    endfunction

    function automatic logic [CFG_WIDTH-1:0] pick_default(input int phase);
        if (phase == 0)
            return '0;
        if (phase == 1)
            return '1;
        return ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 1000000);
    endfunction

    function automatic logic [CONF_WIDTH-1:0] pick_conf(input logic [CONF_WIDTH-1:0] thr);
        case ($urandom_range(0, 5))
            0:       return thr - 1'b1;
            1:       return thr;
            2:       return thr + 1'b1;
            3:       return '0;
            4:       return '1;
            default: return CONF_WIDTH'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [RATE_WIDTH-1:0] pick_rate();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            2:       return tracker.floor_bps + $urandom_range(0, 2) - 1;
            default: return $urandom;
        endcase
    endfunction

    task automatic configure_phase(input int phase);
        drain();
        write_reg(REG_PROBE_CONF_THR, pick_threshold(phase));
        write_reg(REG_ECN_CONF_THR, pick_threshold(phase));
        write_reg(REG_ACKED_CONF_THR, pick_threshold(phase));
        write_reg(REG_RECENT_WINDOW, pick_window(phase));
        write_reg(REG_RATE_FLOOR, pick_floor(phase));
        write_reg(REG_DEFAULT_RATE, pick_default(phase));
        write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
        cfg_valid = 1'b0;
    endtask

    task automatic run_random_phase(input int count);
        logic [63:0]           wide;
        logic [63:0]           step_cap;
        logic [MODE_WIDTH-1:0] op;
        logic [CONF_WIDTH-1:0] thr;
        for (int i = 0; i < count; i++)
        begin
            step_cap = (tracker.window_us > 32'd64) ? {32'd0, tracker.window_us} / 8 : 64'd2;
            case ($urandom_range(0, 19))
                0:
                begin
                    wide = {$urandom, $urandom};
                    now_t = wide[TIME_WIDTH-1:0];
                end
                1:       now_t = now_t - TIME_WIDTH'($urandom_range(1, 5000));
                2, 3:    now_t = tracker.src_stamp[$urandom_range(0, 2)]
                                 + TIME_WIDTH'(tracker.window_us) - 1'b1
                                 + TIME_WIDTH'($urandom_range(0, 1));
                default: now_t = now_t + TIME_WIDTH'($urandom_range(0, step_cap[31:0]));
            endcase
            case ($urandom_range(0, 3))
                0:
                begin
                    op = MODE_ECN;
                    thr = tracker.ecn_thr;
                end
                1:
                begin
                    op = MODE_PROBE;
                    thr = tracker.probe_thr;
                end
                2:
                begin
                    op = MODE_ACKED;
                    thr = tracker.acked_thr;
                end
                default:
                begin
                    op = MODE_QUERY;
                    thr = CONF_WIDTH'($urandom_range(0, 65535));
                end
            endcase
            send_estimate(op, pick_rate(), pick_conf(thr), now_t);
        end
    endtask

    initial
    begin
        tracker = new();
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings: window 10 s, floor 20 kbps, default 300 kbps
        send_estimate(MODE_QUERY, '1, '1, 48'd0);
        send_estimate(MODE_ECN, 32'd0, 16'hFFFF, 48'd1000);
        send_estimate(MODE_ECN, '1, RST_ECN_CONF_THR, 48'd2000);
        send_estimate(MODE_PROBE, 32'd5000000, RST_PROBE_CONF_THR + 1'b1, 48'd3000);
        send_estimate(MODE_ECN, 32'd1000000, RST_ECN_CONF_THR + 1'b1, 48'd4000);
        send_estimate(MODE_ACKED, 32'd7000000, RST_ACKED_CONF_THR + 1'b1, 48'd5000);
        send_estimate(MODE_ACKED, 32'd7000000, RST_ACKED_CONF_THR, 48'd6000);
        send_estimate(MODE_QUERY, '0, '0, 48'd4000 + RST_RECENT_WINDOW - 1);
        send_estimate(MODE_QUERY, '0, '0, 48'd4000 + RST_RECENT_WINDOW);
        send_estimate(MODE_QUERY, '0, '0, 48'd2000);
        // stamp at the top of the time range, then a query after the wrap
        send_estimate(MODE_ECN, 32'd100, 16'd0, '1);
        send_estimate(MODE_QUERY, '1, '1, 48'd5);
        // equal low confidence on all three sources
        send_estimate(MODE_PROBE, 32'd60000, 16'd1000, 48'd10);
        send_estimate(MODE_ACKED, 32'd50000, 16'd1000, 48'd10);
        send_estimate(MODE_ECN, 32'd40000, 16'd1000, 48'd10);
        send_estimate(MODE_QUERY, '0, '0, 48'd10);
        send_estimate(MODE_QUERY, '0, '0, 48'd10 + 48'h8000_0000_0000);
        send_estimate(MODE_QUERY, '0, '0, 48'd10 + 48'h7FFF_FFFF_FFFF);
        // zero confidence everywhere falls back to the default rate
        send_estimate(MODE_ECN, '1, 16'd0, 48'd20);
        send_estimate(MODE_PROBE, '1, 16'd0, 48'd20);
        send_estimate(MODE_ACKED, '1, 16'd0, 48'd20);
        send_estimate(MODE_QUERY, '0, '0, 48'd20);
        send_estimate(MODE_PROBE, 32'd0, 16'hFFFF, 48'd30);
        directed_items = items_sent;
        now_t = 48'd30;

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            configure_phase(phase);
            run_random_phase(PHASE_ITEMS);
        end

        drain();
        repeat (8) @(posedge clk);
        $display("sent %0d estimate transactions (%0d directed) over %0d register settings",
                 items_sent, directed_items, RANDOM_PHASES + 1);
        $display("%0d register writes, %0d results compared, %0d failures",
                 cfg_writes, tracker.checked, tracker.failures);
        if (tracker.failures == 0)
            $display("PASS bandwidth_estimate_fusion_core");
        else
            $display("FAIL bandwidth_estimate_fusion_core");
        $finish;
    end

endmodule
